### design/yti_pkg.sv
// Package for the YUY2 to I420 converter: sample widths, register indexes
// and the word types moved between pipeline stages. No dependencies.
package yti_pkg;

   localparam int PIXEL_W  = 8;
   localparam int CSR_W    = 13;
   localparam int ROW_W    = 12;
   localparam int MAX_ROWS = 4096;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // macropixel as it travels from accept to the output register
   typedef struct packed {
      logic [PIXEL_W-1:0] luma_even;
      logic [PIXEL_W-1:0] chroma_blue;
      logic [PIXEL_W-1:0] luma_odd;
      logic [PIXEL_W-1:0] chroma_red;
      logic               second_ok;
      logic               avg_row;
      logic               pass_row;
      logic               row_end;
      logic               frame_end;
   } stage_word_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] luma_first_out;
      logic [PIXEL_W-1:0] luma_second_out;
      logic               luma_second_valid;
      logic               chroma_valid;
      logic [PIXEL_W-1:0] u_plane_out;
      logic [PIXEL_W-1:0] v_plane_out;
      logic               row_end;
      logic               frame_end;
   } rsp_word_type;

endpackage

### design/yti_if.sv
// Valid/ready channel interfaces for the YUY2 to I420 converter.
// Depends on yti_pkg for the sample width.
interface yti_req_if import yti_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] luma_even;
   logic [PIXEL_W-1:0] chroma_blue;
   logic [PIXEL_W-1:0] luma_odd;
   logic [PIXEL_W-1:0] chroma_red;

   modport source (output valid, luma_even, chroma_blue, luma_odd, chroma_red,
                   input ready);
   modport sink   (input valid, luma_even, chroma_blue, luma_odd, chroma_red,
                   output ready);
endinterface

interface yti_rsp_if import yti_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] luma_first_out;
   logic [PIXEL_W-1:0] luma_second_out;
   logic               luma_second_valid;
   logic               chroma_valid;
   logic [PIXEL_W-1:0] u_plane_out;
   logic [PIXEL_W-1:0] v_plane_out;
   logic               row_end;
   logic               frame_end;

   modport source (output valid, luma_first_out, luma_second_out, luma_second_valid,
                   chroma_valid, u_plane_out, v_plane_out, row_end, frame_end,
                   input ready);
   modport sink   (input valid, luma_first_out, luma_second_out, luma_second_valid,
                   chroma_valid, u_plane_out, v_plane_out, row_end, frame_end,
                   output ready);
endinterface

### design/yti_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module yti_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/yuy2_to_i420_convert_core.sv
// Top level of the YUY2 to I420 converter: counters, chroma line store,
// averaging and output register. Depends on yti_pkg, yti_if.sv, yti_ram.
//
//   Channel   Dir  Handshake      Carries
//   req_word  in   valid/ready    one YUY2 macropixel (Y0, U, Y1, V)
//   rsp_word  out  valid/ready    Y0, Y1, averaged or passed-through U/V, row/frame marks
//   csr_*     in   write enable   frame_width (index 0), frame_height (index 1)
//
// One macropixel a clock sustained while rsp_word is not stalled; a word passes through
// two register stages, stage 1 and the output register, before rsp_word.valid rises.
// Stage 0 reads or writes the line store at the column address; stage 1 holds the
// registered read data and feeds the rounded average into the output register.
// reset is synchronous; the line store is not cleared (each entry is written on
// the first row of a pair before the second row reads it).
// A stall on rsp_word backs up through stage 1 to req_word.ready; the stalled RAM
// read data holds because no new read is issued.
module yuy2_to_i420_convert_core import yti_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   yti_req_if.sink                    req_word,
   yti_rsp_if.source                  rsp_word,
   input  logic                       csr_write_en,
   input  csr_index_type              csr_index,
   input  logic [CSR_W-1:0]           csr_write_data
);

   localparam int DEPTH  = (MAX_WIDTH + 1) / 2;
   localparam int CW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WCMP_W = CSR_W + 1;
   localparam int RST_W  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
   localparam logic [WCMP_W-1:0] MAXW = WCMP_W'(MAX_WIDTH);
   localparam logic [CW-1:0]     RST_MP_LAST = CW'((RST_W - 1) / 2);
   localparam logic              RST_ODD     = 1'((RST_W % 2));
   localparam logic [ROW_W-1:0]  RST_H_LAST  = ROW_W'(479);

   // frame geometry, prepared at register write
   logic [CW-1:0]    mp_last_ff, mp_last_in;
   logic             width_odd_ff, width_odd_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;

   // raster position
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // pipeline
   logic             s1_valid_ff, s1_valid_in;
   stage_word_type   s1_ff, s1_in;
   logic             out_valid_ff, out_valid_in;
   rsp_word_type     out_ff, out_in;

   logic             accept, s1_adv, last_col, last_row, odd_row;
   logic             ram_we, ram_re;
   logic [2*PIXEL_W-1:0] ram_rdata;
   logic [WCMP_W-1:0]    w_clamp;
   logic [PIXEL_W:0]     u_sum, v_sum;

   // --- configuration: clamp and derive the per-frame limits ---
   always_comb begin
      mp_last_in   = mp_last_ff;
      width_odd_in = width_odd_ff;
      h_last_in    = h_last_ff;
      w_clamp      = {1'b0, csr_write_data};
      if (csr_write_data == '0) begin
         w_clamp = WCMP_W'(1);
      end else if ({1'b0, csr_write_data} > MAXW) begin
         w_clamp = MAXW;
      end
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               mp_last_in   = CW'((w_clamp - WCMP_W'(1)) >> 1);
               width_odd_in = w_clamp[0];
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_write_data == '0) begin
                  h_last_in = '0;
               end else if (csr_write_data > CSR_W'(MAX_ROWS)) begin
                  h_last_in = ROW_W'(MAX_ROWS - 1);
               end else begin
                  h_last_in = ROW_W'(csr_write_data - CSR_W'(1));
               end
            end
            default: begin
            end
         endcase
      end
   end

   // --- handshake ---
   assign s1_adv         = s1_valid_ff && (!out_valid_ff || rsp_word.ready);
   assign req_word.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_word.valid && req_word.ready;

   // --- stage 0: position flags and line-store access ---
   assign last_col = (col_ff == mp_last_ff);
   assign last_row = (row_ff == h_last_ff);
   assign odd_row  = row_ff[0];
   // first row of a pair stores chroma; second row reads it back
   assign ram_we   = accept && !odd_row && !last_row;
   assign ram_re   = accept && odd_row;

   yti_ram #(
      .WIDTH (2 * PIXEL_W),
      .DEPTH (DEPTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (col_ff),
      .wr_data ({req_word.chroma_red, req_word.chroma_blue}),
      .rd_en   (ram_re),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write_en) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      s1_in.luma_even   = req_word.luma_even;
      s1_in.chroma_blue = req_word.chroma_blue;
      s1_in.luma_odd    = req_word.luma_odd;
      s1_in.chroma_red  = req_word.chroma_red;
      s1_in.second_ok   = !(last_col && width_odd_ff);
      s1_in.avg_row     = odd_row;
      s1_in.pass_row    = !odd_row && last_row;
      s1_in.row_end     = last_col;
      s1_in.frame_end   = last_col && last_row;
      s1_valid_in       = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   // --- stage 1: rounded vertical average, or chroma passed through on an unpaired last row ---
   assign u_sum = {1'b0, ram_rdata[PIXEL_W-1:0]} + {1'b0, s1_ff.chroma_blue}
                  + (PIXEL_W+1)'(1);
   assign v_sum = {1'b0, ram_rdata[2*PIXEL_W-1:PIXEL_W]} + {1'b0, s1_ff.chroma_red}
                  + (PIXEL_W+1)'(1);

   always_comb begin
      out_in.luma_first_out    = s1_ff.luma_even;
      out_in.luma_second_out   = s1_ff.second_ok ? s1_ff.luma_odd : '0;
      out_in.luma_second_valid = s1_ff.second_ok;
      out_in.chroma_valid      = s1_ff.avg_row || s1_ff.pass_row;
      out_in.u_plane_out       = '0;
      out_in.v_plane_out       = '0;
      if (s1_ff.avg_row) begin
         out_in.u_plane_out = u_sum[PIXEL_W:1];
         out_in.v_plane_out = v_sum[PIXEL_W:1];
      end else if (s1_ff.pass_row) begin
         out_in.u_plane_out = s1_ff.chroma_blue;
         out_in.v_plane_out = s1_ff.chroma_red;
      end
      out_in.row_end   = s1_ff.row_end;
      out_in.frame_end = s1_ff.frame_end;
      out_valid_in     = s1_adv ? 1'b1 : (rsp_word.ready ? 1'b0 : out_valid_ff);
   end

   // --- registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         mp_last_ff   <= RST_MP_LAST;
         width_odd_ff <= RST_ODD;
         h_last_ff    <= RST_H_LAST;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mp_last_ff   <= mp_last_in;
         width_odd_ff <= width_odd_in;
         h_last_ff    <= h_last_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         out_ff <= out_in;
      end
   end

   // --- output channel ---
   assign rsp_word.valid             = out_valid_ff;
   assign rsp_word.luma_first_out    = out_ff.luma_first_out;
   assign rsp_word.luma_second_out   = out_ff.luma_second_out;
   assign rsp_word.luma_second_valid = out_ff.luma_second_valid;
   assign rsp_word.chroma_valid      = out_ff.chroma_valid;
   assign rsp_word.u_plane_out       = out_ff.u_plane_out;
   assign rsp_word.v_plane_out       = out_ff.v_plane_out;
   assign rsp_word.row_end           = out_ff.row_end;
   assign rsp_word.frame_end         = out_ff.frame_end;

`ifndef ASSERT_OFF
   a_ram_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("line store read and written in one cycle");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= mp_last_ff)
      else $error("column counter beyond row length");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_last_ff)
      else $error("row counter beyond frame height");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_word.ready) |-> !req_word.ready)
      else $error("input taken while both stages are blocked");

   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> $stable(ram_rdata))
      else $error("line store data lost under stall");
`endif

endmodule
